/* hw/rtl/iq_multimode_demodulator_core_assert.svh */
// Assertion macros for the multimode I/Q demodulator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef IQ_MULTIMODE_DEMODULATOR_CORE_ASSERT_SVH
`define IQ_MULTIMODE_DEMODULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IMD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/imd_pkg.sv */
// Shared constants, register codes and helper functions for the demodulator.
// No dependencies; imported by the interface, multiplier and core files.
package imd_pkg;

    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int ANGLE_ITER_DEF     = 16;
    localparam int ACC_W              = 48;
    localparam int MUL_AW             = 49;
    localparam int MUL_BW             = 18;
    localparam int MUL_PW             = MUL_AW + MUL_BW;
    localparam int SUM_W              = MUL_PW + 1;
    localparam int DIV_STEPS          = 34;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_IDX_W          = 3;

    localparam logic [2:0] MODE_WFM   = 3'd0;
    localparam logic [2:0] MODE_NFM   = 3'd1;
    localparam logic [2:0] MODE_AM    = 3'd2;
    localparam logic [2:0] MODE_USB   = 3'd3;
    localparam logic [2:0] MODE_LSB   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEEMPH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SB_LPF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DC_BLOCK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SQUELCH  = 3'd5;

    localparam logic [15:0] DEEMPH_RST = 16'd65173;
    localparam logic [15:0] SB_LPF_RST = 16'd65023;
    localparam logic [15:0] DC_BLK_RST = 16'd64684;
    localparam logic [15:0] VOLUME_RST = 16'd256;

    localparam logic [29:0] PI_Q24     = 30'd52707179;
    localparam logic [17:0] FM_GAIN    = 18'd16000;
    localparam logic [17:0] PEAK_DECAY = 18'd65470;
    localparam logic [17:0] AM_GAIN    = 18'd58982;
    localparam logic [17:0] PCM_SCALE  = 18'd32767;

    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(64'sd140737488355327);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

    function automatic logic [23:0] atan_q24(input logic [4:0] k);
        logic [23:0] r;
        case (k)
            5'd0:    r = 24'd13176795;
            5'd1:    r = 24'd7778716;
            5'd2:    r = 24'd4110060;
            5'd3:    r = 24'd2086331;
            5'd4:    r = 24'd1047214;
            5'd5:    r = 24'd524117;
            5'd6:    r = 24'd262123;
            5'd7:    r = 24'd131069;
            default: r = (k < 5'd24) ? (24'd65536 >> (k - 5'd8)) : 24'd0;
        endcase
        return r;
    endfunction

    // Saturate a wide sum into the 48-bit accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > ACC_MAX)
            r = ACC_MAX[ACC_W-1:0];
        else if (v < ACC_MIN)
            r = ACC_MIN[ACC_W-1:0];
        else
            r = v[ACC_W-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/imd_if.sv */
// Valid/ready channel interfaces for I/Q words in and audio words out.
// Depends on imd_pkg for default widths.
interface imd_iq_if
    import imd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] i_sample;
    logic signed [SAMPLE_BITS-1:0] q_sample;

    modport source (output valid, i_sample, q_sample, input ready);
    modport sink   (input valid, i_sample, q_sample, output ready);
endinterface

interface imd_audio_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] audio_sample;
    logic               squelch_closed;

    modport source (output valid, audio_sample, squelch_closed, input ready);
    modport sink   (input valid, audio_sample, squelch_closed, output ready);
endinterface

/* hw/rtl/imd_mul.sv */
// Shared signed multiplier with registered product.
// Depends on imd_pkg for default operand widths.
module imd_mul
    import imd_pkg::*;
#(
    parameter int AW = MUL_AW,
    parameter int BW = MUL_BW
)
(
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    logic signed [AW+BW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

/* hw/rtl/iq_multimode_demodulator_core.sv */
// Multimode I/Q demodulator: one sequencer around one shared multiplier, plus
// a CORDIC/sqrt/divide step unit. AM runs 18 sqrt steps and 34 divide steps;
// NFM and WFM run the CORDIC iterations. A new word is accepted only in idle,
// after the last word has left the sequencer; a held output word stalls the
// sequencer. Reset (async, active low) clears the sequencer, filter and history
// state and loads the register defaults; a mode write clears filter/history state.
module iq_multimode_demodulator_core
    import imd_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    imd_iq_if.sink                iq,
    imd_audio_if.source           audio,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
`include "iq_multimode_demodulator_core_assert.svh"

    localparam int S    = SAMPLE_BITS;
    localparam int XW   = 2 * S + 1;
    localparam int CW   = 2 * S + 28;
    localparam int NIT  = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;
    localparam int SQSH = 34 - 2 * S;

    localparam logic [4:0] ST_IDLE = 5'd0,  ST_F0 = 5'd1,  ST_F1 = 5'd2,  ST_F2 = 5'd3;
    localparam logic [4:0] ST_F3   = 5'd4,  ST_F4 = 5'd5,  ST_CORD = 5'd6, ST_FM0 = 5'd7;
    localparam logic [4:0] ST_FM1  = 5'd8,  ST_WFM = 5'd9, ST_A0 = 5'd10,  ST_A1 = 5'd11;
    localparam logic [4:0] ST_A2   = 5'd12, ST_SQRT = 5'd13, ST_A3 = 5'd14, ST_A4 = 5'd15;
    localparam logic [4:0] ST_A5   = 5'd16, ST_A6 = 5'd17, ST_A7 = 5'd18,  ST_A8 = 5'd19;
    localparam logic [4:0] ST_DIV  = 5'd20, ST_S0 = 5'd21, ST_S1 = 5'd22,  ST_S2 = 5'd23;
    localparam logic [4:0] ST_O0   = 5'd24, ST_O1 = 5'd25, ST_O2 = 5'd26,  ST_DONE = 5'd27;

    logic [4:0]                state_reg;
    logic [2:0]                mode_reg;
    logic [15:0]               deemph_reg, sb_lpf_reg, dc_coef_reg, volume_reg;
    logic [14:0]               squelch_reg;

    logic signed [S-1:0]       in_i_reg, in_q_reg, last_i_reg, last_q_reg;
    logic signed [ACC_W-1:0]   lp_reg, m_reg;
    logic [23:0]               dc_reg, peak_reg;
    logic [1:0]                phase_reg;
    logic signed [CW-1:0]      cx_reg, cy_reg;
    logic signed [29:0]        cz_reg;
    logic [5:0]                cnt_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [34:0]               sq_v_reg, sq_bit_reg, sq_r_reg;
    logic [17:0]               e_reg;
    logic [DIV_STEPS-1:0]      num_reg;
    logic [23:0]               rem_reg;
    logic                      neg_reg, closed_reg;
    logic signed [15:0]        res_reg;
    logic                      ov_reg;
    logic signed [15:0]        out_audio_reg;
    logic                      out_closed_reg;

    logic signed [MUL_AW-1:0]  mul_a;
    logic signed [MUL_BW-1:0]  mul_b;
    logic signed [MUL_PW-1:0]  mul_p;

    imd_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    logic signed [SUM_W-1:0]   p_ext, sum_p, diff_p, wfm_sum;
    logic signed [XW-1:0]      dot_c, cross_c, dot_abs;
    logic signed [ACC_W-1:0]   wfm_acc, ssb_acc;
    logic signed [CW-1:0]      cx_sh, cy_sh;
    logic [23:0]               at_c;
    logic [34:0]               sq_t;
    logic [17:0]               mag_c, e_c;
    logic [23:0]               dcn_c, pk_c;
    logic signed [24:0]        am_diff;
    logic [24:0]               rem2;
    logic                      div_ge;
    logic [16:0]               one_m_d, one_m_b, mabs_c;
    logic signed [S:0]         ssb_x;
    logic signed [17:0]        ssb_x18;
    logic [14:0]               pm_c, pm_g;
    logic                      closed_c;
    logic [22:0]               v_c;
    logic signed [15:0]        res_c;
    logic                      loading;

    assign p_ext   = SUM_W'(mul_p);
    assign sum_p   = sum_reg + p_ext;
    assign diff_p  = sum_reg - p_ext;
    assign dot_c   = XW'(sum_p);
    assign cross_c = XW'(diff_p);
    assign dot_abs = dot_c[XW-1] ? -dot_c : dot_c;
    assign wfm_sum = SUM_W'(m_reg) + (p_ext >>> 16);
    assign wfm_acc = sat_acc(wfm_sum);
    assign ssb_acc = sat_acc(sum_p >>> 16);

    // CORDIC vectoring step; shifts are floor shifts
    assign cx_sh = cx_reg >>> cnt_reg;
    assign cy_sh = cy_reg >>> cnt_reg;
    assign at_c  = atan_q24(cnt_reg[4:0]);

    assign sq_t    = sq_r_reg + sq_bit_reg;
    assign mag_c   = sq_r_reg[17:0];
    assign dcn_c   = 24'(sum_p >>> 16);
    assign am_diff = signed'({7'd0, mag_c}) - signed'({1'b0, dcn_c});
    assign e_c     = am_diff[24] ? 18'(-am_diff) : 18'(am_diff);
    assign pk_c    = 24'(mul_p >>> 16);
    assign rem2    = {rem_reg, num_reg[DIV_STEPS-1]};
    assign div_ge  = rem2 >= {1'b0, peak_reg};
    assign one_m_d = 17'h10000 - {1'b0, dc_coef_reg};
    assign one_m_b = 17'h10000 - {1'b0, sb_lpf_reg};

    always_comb
    begin
        case (phase_reg)
            2'd0:    ssb_x = (S+1)'(in_i_reg);
            2'd1:    ssb_x = (mode_reg == MODE_USB) ? -(S+1)'(in_q_reg) : (S+1)'(in_q_reg);
            2'd2:    ssb_x = -(S+1)'(in_i_reg);
            default: ssb_x = (mode_reg == MODE_USB) ? (S+1)'(in_q_reg) : -(S+1)'(in_q_reg);
        endcase
    end
    assign ssb_x18 = 18'(ssb_x) <<< (17 - S);

    // Clamp to +-1.0 in Q16 and take the magnitude
    always_comb
    begin
        if (m_reg > ACC_W'(65536) || m_reg < -ACC_W'(65536))
            mabs_c = 17'h10000;
        else if (m_reg[ACC_W-1])
            mabs_c = 17'(-m_reg);
        else
            mabs_c = 17'(m_reg);
    end

    assign pm_c     = mul_p[30:16];
    assign closed_c = (squelch_reg != 15'd0) && (pm_c < squelch_reg);
    assign pm_g     = closed_c ? 15'd0 : pm_c;
    assign v_c      = mul_p[30:8];

    always_comb
    begin
        if (neg_reg)
            res_c = (v_c > 23'd32768) ? -16'sd32768 : 16'(-signed'({1'b0, v_c}));
        else
            res_c = (v_c > 23'd32767) ? 16'sd32767 : 16'(v_c);
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_F0:  begin mul_a = MUL_AW'(last_i_reg); mul_b = MUL_BW'(in_q_reg); end
            ST_F1:  begin mul_a = MUL_AW'(last_q_reg); mul_b = MUL_BW'(in_i_reg); end
            ST_F2:  begin mul_a = MUL_AW'(last_i_reg); mul_b = MUL_BW'(in_i_reg); end
            ST_F3:  begin mul_a = MUL_AW'(last_q_reg); mul_b = MUL_BW'(in_q_reg); end
            ST_FM0: begin mul_a = MUL_AW'(cz_reg); mul_b = FM_GAIN; end
            ST_FM1: begin mul_a = MUL_AW'(lp_reg); mul_b = signed'({2'b0, deemph_reg}); end
            ST_A0:  begin mul_a = MUL_AW'(in_i_reg); mul_b = MUL_BW'(in_i_reg); end
            ST_A1:  begin mul_a = MUL_AW'(in_q_reg); mul_b = MUL_BW'(in_q_reg); end
            ST_A3:  begin mul_a = signed'(MUL_AW'(mag_c)); mul_b = signed'({1'b0, one_m_d}); end
            ST_A4:  begin mul_a = signed'(MUL_AW'(dc_reg)); mul_b = signed'({2'b0, dc_coef_reg}); end
            ST_A5:  begin mul_a = signed'(MUL_AW'(peak_reg)); mul_b = PEAK_DECAY; end
            ST_A7:  begin mul_a = signed'(MUL_AW'(e_reg)); mul_b = AM_GAIN; end
            ST_S0:  begin mul_a = MUL_AW'(ssb_x18); mul_b = signed'({1'b0, one_m_b}); end
            ST_S1:  begin mul_a = MUL_AW'(lp_reg); mul_b = signed'({2'b0, sb_lpf_reg}); end
            ST_O0:  begin mul_a = signed'(MUL_AW'(mabs_c)); mul_b = PCM_SCALE; end
            ST_O1:  begin mul_a = signed'(MUL_AW'(pm_g)); mul_b = signed'({2'b0, volume_reg}); end
            default: ;
        endcase
    end

    assign loading      = (state_reg == ST_DONE) && (!ov_reg || audio.ready);
    assign iq.ready     = (state_reg == ST_IDLE);
    assign audio.valid  = ov_reg;
    assign audio.audio_sample   = out_audio_reg;
    assign audio.squelch_closed = out_closed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_WFM;
            deemph_reg  <= DEEMPH_RST;
            sb_lpf_reg  <= SB_LPF_RST;
            dc_coef_reg <= DC_BLK_RST;
            volume_reg  <= VOLUME_RST;
            squelch_reg <= '0;
            last_i_reg  <= '0;
            last_q_reg  <= '0;
            lp_reg      <= '0;
            dc_reg      <= '0;
            peak_reg    <= '0;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (loading)
                ov_reg <= 1'b1;
            else if (audio.ready)
                ov_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (iq.valid)
                    begin
                        in_i_reg <= iq.i_sample;
                        in_q_reg <= iq.q_sample;
                        case (mode_reg)
                            MODE_AM:            state_reg <= ST_A0;
                            MODE_USB, MODE_LSB: state_reg <= ST_S0;
                            default:            state_reg <= ST_F0;
                        endcase
                    end
                end
                ST_F0: state_reg <= ST_F1;
                ST_F1:
                begin
                    sum_reg   <= p_ext;
                    state_reg <= ST_F2;
                end
                ST_F2:
                begin
                    cy_reg    <= {{(CW-XW-24){cross_c[XW-1]}}, cross_c, 24'd0};
                    state_reg <= ST_F3;
                end
                ST_F3:
                begin
                    sum_reg   <= p_ext;
                    state_reg <= ST_F4;
                end
                ST_F4:
                begin
                    last_i_reg <= in_i_reg;
                    last_q_reg <= in_q_reg;
                    cnt_reg    <= '0;
                    if (dot_c == '0 && cy_reg == '0)
                    begin
                        cz_reg    <= '0;
                        state_reg <= ST_FM0;
                    end
                    else
                    begin
                        cx_reg    <= {{(CW-XW-24){dot_abs[XW-1]}}, dot_abs, 24'd0};
                        state_reg <= ST_CORD;
                        if (dot_c[XW-1])
                        begin
                            // turn a left-half vector over by pi
                            cz_reg <= cy_reg[CW-1] ? -signed'(PI_Q24) : signed'(PI_Q24);
                            cy_reg <= -cy_reg;
                        end
                        else
                            cz_reg <= '0;
                    end
                end
                ST_CORD:
                begin
                    if (!cy_reg[CW-1])
                    begin
                        cx_reg <= cx_reg + cy_sh;
                        cy_reg <= cy_reg - cx_sh;
                        cz_reg <= cz_reg + signed'(30'(at_c));
                    end
                    else
                    begin
                        cx_reg <= cx_reg - cy_sh;
                        cy_reg <= cy_reg + cx_sh;
                        cz_reg <= cz_reg - signed'(30'(at_c));
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(NIT - 1))
                        state_reg <= ST_FM0;
                end
                ST_FM0: state_reg <= ST_FM1;
                ST_FM1:
                begin
                    m_reg     <= ACC_W'(mul_p >>> 8);
                    state_reg <= (mode_reg == MODE_NFM) ? ST_O0 : ST_WFM;
                end
                ST_WFM:
                begin
                    lp_reg    <= wfm_acc;
                    m_reg     <= wfm_acc;
                    state_reg <= ST_O0;
                end
                ST_A0: state_reg <= ST_A1;
                ST_A1:
                begin
                    sum_reg   <= p_ext;
                    state_reg <= ST_A2;
                end
                ST_A2:
                begin
                    sq_v_reg   <= 35'(unsigned'(dot_c)) << SQSH;
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 35'd1 << 34;
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sq_v_reg >= sq_t)
                    begin
                        sq_v_reg <= sq_v_reg - sq_t;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                        state_reg <= ST_A3;
                end
                ST_A3: state_reg <= ST_A4;
                ST_A4:
                begin
                    sum_reg   <= p_ext;
                    state_reg <= ST_A5;
                end
                ST_A5:
                begin
                    dc_reg <= dcn_c;
                    e_reg  <= e_c;
                    if (24'(e_c) > peak_reg)
                    begin
                        peak_reg  <= 24'(e_c);
                        state_reg <= ST_A7;
                    end
                    else
                        state_reg <= ST_A6;
                end
                ST_A6:
                begin
                    peak_reg  <= (pk_c == '0) ? 24'd1 : pk_c;
                    state_reg <= ST_A7;
                end
                ST_A7: state_reg <= ST_A8;
                ST_A8:
                begin
                    num_reg   <= mul_p[DIV_STEPS-1:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= div_ge ? 24'(rem2 - {1'b0, peak_reg}) : rem2[23:0];
                    num_reg <= {num_reg[DIV_STEPS-2:0], div_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1))
                    begin
                        m_reg     <= ACC_W'({num_reg[DIV_STEPS-2:0], div_ge});
                        state_reg <= ST_O0;
                    end
                end
                ST_S0: state_reg <= ST_S1;
                ST_S1:
                begin
                    sum_reg   <= p_ext;
                    state_reg <= ST_S2;
                end
                ST_S2:
                begin
                    lp_reg    <= ssb_acc;
                    m_reg     <= ssb_acc;
                    phase_reg <= phase_reg + 2'd1;
                    state_reg <= ST_O0;
                end
                ST_O0:
                begin
                    neg_reg   <= m_reg[ACC_W-1];
                    state_reg <= ST_O1;
                end
                ST_O1:
                begin
                    closed_reg <= closed_c;
                    state_reg  <= ST_O2;
                end
                ST_O2:
                begin
                    res_reg   <= res_c;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (loading)
                    begin
                        out_audio_reg  <= res_reg;
                        out_closed_reg <= closed_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_MODE:
                    begin
                        mode_reg   <= cfg_data[2:0];
                        last_i_reg <= '0;
                        last_q_reg <= '0;
                        lp_reg     <= '0;
                        dc_reg     <= '0;
                        peak_reg   <= '0;
                        phase_reg  <= '0;
                    end
                    REG_DEEMPH:   deemph_reg  <= cfg_data;
                    REG_SB_LPF:   sb_lpf_reg  <= cfg_data;
                    REG_DC_BLOCK: dc_coef_reg <= cfg_data;
                    REG_VOLUME:   volume_reg  <= cfg_data;
                    REG_SQUELCH:  squelch_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

    `IMD_ASSERT_NOW(a_ready_idle, iq.ready, state_reg == ST_IDLE, "ready outside idle")
    `IMD_ASSERT_NOW(a_squelch_zero, audio.valid && audio.squelch_closed,
        audio.audio_sample == 16'sd0, "closed squelch with nonzero audio")
    `IMD_ASSERT_NOW(a_div_peak, state_reg == ST_DIV, peak_reg != 24'd0, "divide by zero peak")
    `IMD_ASSERT_NEXT(a_accept_leaves, iq.valid && iq.ready, state_reg != ST_IDLE,
        "accepted word did not start the sequencer")

endmodule
